/* rtl/i2cbs_pkg.sv */
package i2cbs_pkg;

  // Command codes carried on the request kind
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_NACK    = 3'd6,
    CMD_WAITACK = 3'd7
  } cmd_t;

  // Completion status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUS_BUSY = 2'd1,
    ST_BUS_ERR  = 2'd2,
    ST_NO_ACK   = 2'd3
  } status_t;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STEP_W   = 3;
  localparam int unsigned BITCNT_W = 4;

  localparam logic [BYTE_W-1:0]   HPT_RESET  = 8'd50;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // Per-tick result handed from the sequencer to the output register
  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] rx_byte;
    logic              done_res;
    logic              busy_res;
    logic              sda_out;
    logic              scl_out;
  } res_t;

endpackage

/* rtl/i2c_master_bit_sequencer.sv */
// The result of a request is registered and appears on m_tdata in the cycle after it is taken.
// Throughput: one request per cycle while m_tready is high; a result left waiting in
// the output register holds s_tready low until it is taken.
// Reset (rst, synchronous, active high): sequencer idle, SCL and SDA released,
// rx byte and status cleared, half_phase_ticks back to 50, no result pending.
module i2c_master_bit_sequencer
  import i2cbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] sda_in, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
                                 // [11:4] rx_byte, [13:12] status, rest zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              acc;
  logic [BYTE_W-1:0] half_phase_ticks;
  res_t              res;

  assign pready = 1'b1;
  assign acc    = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_phase_ticks <= HPT_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      half_phase_ticks <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32-BYTE_W){1'b0}}, half_phase_ticks};

  i2cbs_core u_core (
    .clk              (clk),
    .rst              (rst),
    .acc              (acc),
    .req_type         (s_tuser),
    .tx_byte          (s_tdata[BYTE_W-1:0]),
    .sda_in           (s_tdata[BYTE_W]),
    .half_phase_ticks (half_phase_ticks),
    .res              (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      m_tdata <= {2'b00, res};
    end
  end

endmodule

/* rtl/i2cbs_core.sv */
module i2cbs_core
  import i2cbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic [2:0]        req_type,
  input  logic [BYTE_W-1:0] tx_byte,
  input  logic              sda_in,
  input  logic [BYTE_W-1:0] half_phase_ticks,
  output res_t              res
);

  logic [STEP_W-1:0]   seq_step, seq_step_next;
  cmd_t                active_cmd, active_cmd_next;
  logic [BITCNT_W-1:0] bit_left, bit_left_next;
  logic [BYTE_W-1:0]   shift_reg, shift_reg_next;
  logic [BYTE_W-1:0]   tick_count, tick_count_next;
  logic                scl_level, scl_level_next;
  logic                sda_level, sda_level_next;
  logic [1:0]          last_status, last_status_next;
  logic [BYTE_W-1:0]   rx_hold, rx_hold_next;
  logic                done_next;
  logic                go;
  logic [STEP_W-1:0]   go_step;
  logic [BYTE_W-1:0]   phase_len;

  // a zero phase length counts as one tick
  assign phase_len = (half_phase_ticks == '0) ? BYTE_W'(1) : half_phase_ticks;

  // a tick starts a command, counts down or ends the phase
  always_comb begin
    seq_step_next    = seq_step;
    active_cmd_next  = active_cmd;
    bit_left_next    = bit_left;
    shift_reg_next   = shift_reg;
    tick_count_next  = tick_count;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    last_status_next = last_status;
    rx_hold_next     = rx_hold;
    done_next        = 1'b0;
    go               = 1'b0;
    go_step          = STEP_W'(1);

    if (seq_step == '0) begin
      if (cmd_t'(req_type) != CMD_NONE) begin
        active_cmd_next = cmd_t'(req_type);
        bit_left_next   = '0;
        shift_reg_next  = '0;
        if (cmd_t'(req_type) == CMD_WRITE) begin
          bit_left_next  = BITS_PER_BYTE;
          shift_reg_next = tx_byte;
        end
        if (cmd_t'(req_type) == CMD_READ) begin
          bit_left_next  = BITS_PER_BYTE;
          sda_level_next = 1'b1;
        end
        go      = 1'b1;
        go_step = STEP_W'(1);
      end
    end else if (tick_count > BYTE_W'(1)) begin
      tick_count_next = tick_count - BYTE_W'(1);
    end else begin
      unique case (active_cmd)
        CMD_START: begin
          if (seq_step == STEP_W'(1)) begin
            if (!sda_in) begin
              seq_step_next = '0; tick_count_next = '0;
              last_status_next = ST_BUS_BUSY; done_next = 1'b1;
            end else begin
              go = 1'b1; go_step = STEP_W'(2);
            end
          end else if (seq_step == STEP_W'(2)) begin
            if (sda_in) begin
              seq_step_next = '0; tick_count_next = '0;
              last_status_next = ST_BUS_ERR; done_next = 1'b1;
            end else begin
              go = 1'b1; go_step = STEP_W'(3);
            end
          end else begin
            seq_step_next = '0; tick_count_next = '0;
            last_status_next = ST_OK; done_next = 1'b1;
          end
        end
        CMD_STOP, CMD_ACK, CMD_NACK, CMD_WAITACK: begin
          // ack result latched at the end of the SCL-high phase
          if (active_cmd == CMD_WAITACK && seq_step == STEP_W'(3)) begin
            shift_reg_next = {{(BYTE_W-1){1'b0}}, sda_in};
          end
          if (seq_step < STEP_W'(4)) begin
            go = 1'b1; go_step = seq_step + STEP_W'(1);
          end else begin
            seq_step_next = '0; tick_count_next = '0; done_next = 1'b1;
            if (active_cmd == CMD_WAITACK && shift_reg_next[0]) begin
              last_status_next = ST_NO_ACK;
            end else begin
              last_status_next = ST_OK;
            end
          end
        end
        CMD_WRITE: begin
          if (seq_step < STEP_W'(3)) begin
            go = 1'b1; go_step = seq_step + STEP_W'(1);
          end else begin
            bit_left_next = bit_left - BITCNT_W'(1);
            if (bit_left_next != '0) begin
              go = 1'b1; go_step = STEP_W'(1);
            end else begin
              scl_level_next = 1'b0;
              seq_step_next = '0; tick_count_next = '0;
              last_status_next = ST_OK; done_next = 1'b1;
            end
          end
        end
        default: begin
          // read byte
          if (seq_step == STEP_W'(1)) begin
            go = 1'b1; go_step = STEP_W'(2);
          end else begin
            shift_reg_next = {shift_reg[BYTE_W-2:0], sda_in};
            bit_left_next  = bit_left - BITCNT_W'(1);
            if (bit_left_next != '0) begin
              go = 1'b1; go_step = STEP_W'(1);
            end else begin
              scl_level_next = 1'b0;
              rx_hold_next   = shift_reg_next;
              seq_step_next = '0; tick_count_next = '0;
              last_status_next = ST_OK; done_next = 1'b1;
            end
          end
        end
      endcase
    end

    // phase entry: reload the phase timer and set the pin drives
    if (go) begin
      seq_step_next   = go_step;
      tick_count_next = phase_len;
      unique case (active_cmd_next)
        CMD_START: begin
          if (go_step == STEP_W'(1)) begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
          end else begin
            sda_level_next = 1'b0;
          end
        end
        CMD_STOP: begin
          if (go_step == STEP_W'(1))      scl_level_next = 1'b0;
          else if (go_step == STEP_W'(2)) sda_level_next = 1'b0;
          else if (go_step == STEP_W'(3)) scl_level_next = 1'b1;
          else                            sda_level_next = 1'b1;
        end
        CMD_ACK, CMD_NACK, CMD_WAITACK: begin
          if (go_step == STEP_W'(1) || go_step == STEP_W'(4)) begin
            scl_level_next = 1'b0;
          end else if (go_step == STEP_W'(2)) begin
            sda_level_next = (active_cmd_next != CMD_ACK);
          end else begin
            scl_level_next = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (go_step == STEP_W'(1)) begin
            scl_level_next = 1'b0;
          end else if (go_step == STEP_W'(2)) begin
            sda_level_next = shift_reg_next[BYTE_W-1];
            shift_reg_next = {shift_reg_next[BYTE_W-2:0], 1'b0};
          end else begin
            scl_level_next = 1'b1;
          end
        end
        default: begin
          scl_level_next = (go_step != STEP_W'(1));
        end
      endcase
    end
  end

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_step    <= '0;
      active_cmd  <= CMD_NONE;
      bit_left    <= '0;
      shift_reg   <= '0;
      tick_count  <= '0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      last_status <= ST_OK;
      rx_hold     <= '0;
    end else if (acc) begin
      seq_step    <= seq_step_next;
      active_cmd  <= active_cmd_next;
      bit_left    <= bit_left_next;
      shift_reg   <= shift_reg_next;
      tick_count  <= tick_count_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      last_status <= last_status_next;
      rx_hold     <= rx_hold_next;
    end
  end

  assign res.scl_out  = scl_level_next;
  assign res.sda_out  = sda_level_next;
  assign res.busy_res = (seq_step_next != '0);
  assign res.done_res = done_next;
  assign res.rx_byte  = rx_hold_next;
  assign res.status   = last_status_next;

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> !res.busy_res)
    else $error("done reported while still busy");

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    (seq_step == '0) |-> (tick_count == '0))
    else $error("phase timer running while idle");

  a_cmd_held: assert property (@(posedge clk) disable iff (rst)
    (acc && seq_step != '0) |=> $stable(active_cmd))
    else $error("active command changed mid sequence");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_left <= BITS_PER_BYTE)
    else $error("bit counter beyond one byte");
`endif

endmodule
